// ===== rtl/imuap_pkg.sv =====
`timescale 1ns / 1ps

package imuap_pkg;

    // frame geometry
    localparam int MAX_FRAME = 64;
    localparam int MAX_LEN   = MAX_FRAME - 5;
    localparam int POS_W     = 9;
    localparam int LEN_W     = 8;
    localparam int BODY_LEN  = 20;
    localparam int BODY_FIRST = 7;
    localparam int BODY_LAST  = 22;
    localparam int OBJ_POS    = 3;

    localparam int BYTE_W = 8;
    localparam int ID_W   = 7;
    localparam int WORD_W = 32;
    localparam int CRC_W  = 16;
    localparam int EV_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    // sign-stripped limits of roll, pitch and yaw
    localparam logic [WORD_W-1:0] LIM_ROLL  = 32'h4334_0000;
    localparam logic [WORD_W-1:0] LIM_PITCH = 32'h42B4_0000;
    localparam logic [WORD_W-1:0] LIM_YAW   = 32'h43B4_0000;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;
    localparam logic [ID_W-1:0]   ATT_ID_RST      = 7'd35;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATT_ID      = 2'd2;

    // event codes
    localparam logic [EV_W-1:0] EV_NONE       = 3'd0;
    localparam logic [EV_W-1:0] EV_ATT_OK     = 3'd1;
    localparam logic [EV_W-1:0] EV_ATT_REJECT = 3'd2;
    localparam logic [EV_W-1:0] EV_OTHER      = 3'd3;
    localparam logic [EV_W-1:0] EV_CRC_ERR    = 3'd4;
    localparam logic [EV_W-1:0] EV_LEN_REJECT = 3'd5;

    typedef struct packed {
        logic       frame_end;
        logic       crc_good;
        logic       obj_match;
        logic       body_len;
        logic       len_reject;
        logic       body_we;
        logic [1:0] body_word;
        logic [1:0] body_lane;
    } trk_status_t;

    function automatic logic [CRC_W-1:0] crc_feed(logic [CRC_W-1:0] crc_in,
                                                  logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== rtl/imuap_frame_tracker.sv =====
`timescale 1ns / 1ps

module imuap_frame_tracker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic [imuap_pkg::BYTE_W-1:0]       rx_byte,
    input  logic [imuap_pkg::BYTE_W-1:0]       sync_first,
    input  logic [imuap_pkg::BYTE_W-1:0]       sync_second,
    input  logic [imuap_pkg::ID_W-1:0]         attitude_id,
    output imuap_pkg::trk_status_t             status
);

    logic [imuap_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                        in_frame_reg, in_frame_next;
    logic [imuap_pkg::LEN_W-1:0] len_reg, len_next;
    logic [imuap_pkg::CRC_W-1:0] crc_reg, crc_next;
    logic                        crc_hi_reg, crc_hi_next;
    logic [imuap_pkg::ID_W-1:0]  obj_reg, obj_next;

    logic [imuap_pkg::POS_W:0]   pos_x;
    logic [imuap_pkg::POS_W:0]   len_x;
    logic [imuap_pkg::POS_W:0]   pos_inc;
    logic [imuap_pkg::POS_W-1:0] body_idx;
    logic                        crc_good;

    assign pos_x    = {1'b0, pos_reg};
    assign len_x    = {{(imuap_pkg::POS_W + 1 - imuap_pkg::LEN_W){1'b0}}, len_reg};
    assign pos_inc  = pos_x + (imuap_pkg::POS_W + 1)'(1);
    assign body_idx = pos_reg - imuap_pkg::POS_W'(imuap_pkg::BODY_FIRST);
    assign crc_good = crc_hi_reg && (rx_byte == crc_reg[imuap_pkg::BYTE_W-1:0]);

    always_comb
    begin
        pos_next      = pos_reg;
        in_frame_next = in_frame_reg;
        len_next      = len_reg;
        crc_next      = crc_reg;
        crc_hi_next   = crc_hi_reg;
        obj_next      = obj_reg;

        status            = '0;
        status.crc_good   = crc_good;
        status.obj_match  = (obj_reg == attitude_id);
        status.body_len   = (len_reg == imuap_pkg::LEN_W'(imuap_pkg::BODY_LEN));
        status.body_word  = body_idx[3:2];
        status.body_lane  = body_idx[1:0];

        if (!in_frame_reg)
        begin
            priority if (pos_reg == imuap_pkg::POS_W'(0) && rx_byte == sync_first)
            begin
                pos_next = imuap_pkg::POS_W'(1);
            end
            else if (pos_reg == imuap_pkg::POS_W'(1) && rx_byte == sync_second)
            begin
                pos_next = imuap_pkg::POS_W'(2);
            end
            else if (pos_reg == imuap_pkg::POS_W'(2))
            begin
                if ({1'b0, rx_byte} > (imuap_pkg::BYTE_W + 1)'(imuap_pkg::MAX_LEN))
                begin
                    pos_next          = '0;
                    len_next          = '0;
                    crc_next          = imuap_pkg::CRC_INIT;
                    crc_hi_next       = 1'b0;
                    status.len_reject = 1'b1;
                end
                else
                begin
                    len_next      = rx_byte;
                    crc_next      = imuap_pkg::crc_feed(imuap_pkg::CRC_INIT, rx_byte);
                    in_frame_next = 1'b1;
                    pos_next      = imuap_pkg::POS_W'(3);
                end
            end
            else
            begin
                // stray byte, may itself open a new sync pair
                pos_next    = (rx_byte == sync_first) ? imuap_pkg::POS_W'(1) : '0;
                len_next    = '0;
                crc_next    = imuap_pkg::CRC_INIT;
                crc_hi_next = 1'b0;
            end
        end
        else
        begin
            if (pos_reg == imuap_pkg::POS_W'(imuap_pkg::OBJ_POS))
                obj_next = rx_byte[imuap_pkg::ID_W-1:0];
            status.body_we = (pos_reg >= imuap_pkg::POS_W'(imuap_pkg::BODY_FIRST)) &&
                             (pos_reg <= imuap_pkg::POS_W'(imuap_pkg::BODY_LAST));

            if (pos_x <= len_x + (imuap_pkg::POS_W + 1)'(2))
                crc_next = imuap_pkg::crc_feed(crc_reg, rx_byte);
            else if (pos_x == len_x + (imuap_pkg::POS_W + 1)'(3))
                crc_hi_next = (rx_byte == crc_reg[imuap_pkg::CRC_W-1:imuap_pkg::BYTE_W]);

            pos_next = pos_inc[imuap_pkg::POS_W-1:0];

            if (pos_x >= len_x + (imuap_pkg::POS_W + 1)'(4) ||
                pos_inc >= (imuap_pkg::POS_W + 1)'(imuap_pkg::MAX_FRAME))
            begin
                status.frame_end = (pos_x >= len_x + (imuap_pkg::POS_W + 1)'(4));
                pos_next         = '0;
                in_frame_next    = 1'b0;
                len_next         = '0;
                crc_next         = imuap_pkg::CRC_INIT;
                crc_hi_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            in_frame_reg <= 1'b0;
            len_reg      <= '0;
            crc_reg      <= imuap_pkg::CRC_INIT;
            crc_hi_reg   <= 1'b0;
            obj_reg      <= '0;
        end
        else if (accept)
        begin
            pos_reg      <= pos_next;
            in_frame_reg <= in_frame_next;
            len_reg      <= len_next;
            crc_reg      <= crc_next;
            crc_hi_reg   <= crc_hi_next;
            obj_reg      <= obj_next;
        end
    end

endmodule

// ===== rtl/imu_attitude_frame_parser.sv =====
`timescale 1ns / 1ps

// channel   | direction | signals                    | contents
// ----------+-----------+----------------------------+----------------------------------------
// s_*       | in        | tvalid tready tdata[7:0]   | rx_byte
// m_*       | out       | tvalid tready tdata tuser  | tdata: time_stamp roll pitch yaw
//           |           |                            |   good_frames crc_failures other_frames
//           |           |                            | tuser: event_res, data_valid
// cfg_*     | in        | we index[1:0] data[7:0]    | sync_first, sync_second, attitude id
//
// one item per cycle while s_tready is high; its result is in the output register the cycle after acceptance
// the sync hunt, crc update and field capture of a byte all take effect on its acceptance
// reset is immediate, no clearing pass; the staged body needs no reset
// m_tready low holds the result; s_tready drops only while a result waits untaken

module imu_attitude_frame_parser (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] rx_byte
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [31:0] time_stamp, [63:32] roll_bits, [95:64] pitch_bits, [127:96] yaw_bits,
    // [159:128] good_frames, [191:160] crc_failures, [223:192] other_frames
    output logic [223:0]                         m_tdata,
    output logic [3:0]                           m_tuser,   // [2:0] event_res, [3] data_valid
    input  logic                                 cfg_we,
    input  logic [imuap_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [imuap_pkg::BYTE_W-1:0]         cfg_data
);

    logic [imuap_pkg::BYTE_W-1:0] sync_first_reg, sync_second_reg;
    logic [imuap_pkg::ID_W-1:0]   att_id_reg;

    logic [imuap_pkg::WORD_W-1:0] staged_reg [4];
    logic [imuap_pkg::WORD_W-1:0] pub_reg    [4];
    logic [imuap_pkg::WORD_W-1:0] pub_next   [4];
    logic                         valid_reg, valid_next;
    logic [imuap_pkg::WORD_W-1:0] good_cnt_reg, good_cnt_next;
    logic [imuap_pkg::WORD_W-1:0] crc_cnt_reg, crc_cnt_next;
    logic [imuap_pkg::WORD_W-1:0] other_cnt_reg, other_cnt_next;
    logic                         out_valid_reg, out_valid_next;
    logic [imuap_pkg::EV_W-1:0]   ev_reg, ev_next, ev_item;

    logic                         accept;
    logic                         angles_ok;
    imuap_pkg::trk_status_t       trk;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    imuap_frame_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (s_tdata),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .attitude_id (att_id_reg),
        .status      (trk)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= imuap_pkg::SYNC_FIRST_RST;
            sync_second_reg <= imuap_pkg::SYNC_SECOND_RST;
            att_id_reg      <= imuap_pkg::ATT_ID_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                imuap_pkg::CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                imuap_pkg::CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                imuap_pkg::CFG_ATT_ID:      att_id_reg      <= cfg_data[imuap_pkg::ID_W-1:0];
                default:                    ;
            endcase
        end
    end

    // body bytes land little-endian in the staged words
    always_ff @(posedge clk)
    begin
        if (accept && trk.body_we)
        begin
            unique case (trk.body_lane)
                2'd0: staged_reg[trk.body_word][7:0]   <= s_tdata;
                2'd1: staged_reg[trk.body_word][15:8]  <= s_tdata;
                2'd2: staged_reg[trk.body_word][23:16] <= s_tdata;
                2'd3: staged_reg[trk.body_word][31:24] <= s_tdata;
                default: ;
            endcase
        end
    end

    assign angles_ok = ({1'b0, staged_reg[1][30:0]} <= imuap_pkg::LIM_ROLL) &&
                       ({1'b0, staged_reg[2][30:0]} <= imuap_pkg::LIM_PITCH) &&
                       ({1'b0, staged_reg[3][30:0]} <= imuap_pkg::LIM_YAW);

    always_comb
    begin
        pub_next       = pub_reg;
        valid_next     = valid_reg;
        good_cnt_next  = good_cnt_reg;
        crc_cnt_next   = crc_cnt_reg;
        other_cnt_next = other_cnt_reg;
        ev_item        = imuap_pkg::EV_NONE;

        if (trk.len_reject)
        begin
            ev_item = imuap_pkg::EV_LEN_REJECT;
        end
        else if (trk.frame_end)
        begin
            priority if (!trk.crc_good)
            begin
                crc_cnt_next = crc_cnt_reg + imuap_pkg::WORD_W'(1);
                ev_item      = imuap_pkg::EV_CRC_ERR;
            end
            else if (!trk.obj_match)
            begin
                other_cnt_next = other_cnt_reg + imuap_pkg::WORD_W'(1);
                ev_item        = imuap_pkg::EV_OTHER;
            end
            else if (trk.body_len)
            begin
                pub_next = staged_reg;
                if (angles_ok)
                begin
                    good_cnt_next = good_cnt_reg + imuap_pkg::WORD_W'(1);
                    valid_next    = 1'b1;
                    ev_item       = imuap_pkg::EV_ATT_OK;
                end
                else
                begin
                    ev_item = imuap_pkg::EV_ATT_REJECT;
                end
            end
            else
            begin
                ev_item = imuap_pkg::EV_ATT_REJECT;
            end
        end

        out_valid_next = out_valid_reg;
        ev_next        = ev_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            ev_next        = ev_item;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                pub_reg[i] <= '0;
            valid_reg     <= 1'b0;
            good_cnt_reg  <= '0;
            crc_cnt_reg   <= '0;
            other_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            ev_reg        <= imuap_pkg::EV_NONE;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            ev_reg        <= ev_next;
            if (accept)
            begin
                pub_reg       <= pub_next;
                valid_reg     <= valid_next;
                good_cnt_reg  <= good_cnt_next;
                crc_cnt_reg   <= crc_cnt_next;
                other_cnt_reg <= other_cnt_next;
            end
        end
    end

    // parse state only moves on acceptance, which also refills the output register
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {valid_reg, ev_reg};
    assign m_tdata  = {other_cnt_reg, crc_cnt_reg, good_cnt_reg,
                       pub_reg[3], pub_reg[2], pub_reg[1], pub_reg[0]};

endmodule

// ===== rtl/imuap_checker.sv =====
`timescale 1ns / 1ps

module imuap_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [223:0] m_tdata,
    input  logic [3:0]   m_tuser
);

    // input is held back only by an untaken result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("s_tready low without a waiting result");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted item gave no result");

    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[2:0] <= 3'd5))
        else $error("event code out of range");

    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(m_tuser[3]))
        else $error("data_valid dropped");

    a_data_moves_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(m_tdata) |-> $past(s_tvalid && s_tready))
        else $error("result data changed without an accepted item");

endmodule

bind imu_attitude_frame_parser imuap_checker u_imuap_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== dv/tb_imu_attitude_frame_parser.sv =====
`timescale 1ns / 1ps

module tb_imu_attitude_frame_parser;

    import imuap_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {FRAME_CLEAN, FRAME_BAD_CRC_HI, FRAME_BAD_CRC_LO, FRAME_CUT} frame_fault_t;

    typedef struct packed {
        logic [EV_W-1:0]   ev;
        logic              valid;
        logic [WORD_W-1:0] ts;
        logic [WORD_W-1:0] roll;
        logic [WORD_W-1:0] pitch;
        logic [WORD_W-1:0] yaw;
        logic [WORD_W-1:0] n_good;
        logic [WORD_W-1:0] n_crc;
        logic [WORD_W-1:0] n_other;
    } parser_out_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [223:0]         m_tdata;
    logic [3:0]           m_tuser;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SYNC_FIRST;
    logic [BYTE_W-1:0]    cfg_data  = 8'h00;

    imu_attitude_frame_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // parser state as the predictor sees it
    logic [7:0]        sync_a;
    logic [7:0]        sync_b;
    logic [ID_W-1:0]   att_id;
    int                pos_q;
    logic              framing;
    logic [7:0]        len_q;
    logic [15:0]       crc_q;
    logic              crc_hi_ok;
    logic [ID_W-1:0]   obj_q;
    logic [31:0]       stage_w [4];
    logic [31:0]       pub_w [4];
    logic              att_valid;
    logic [31:0]       cnt_good;
    logic [31:0]       cnt_crc;
    logic [31:0]       cnt_other;

    logic [7:0]        serial_bytes [$];
    parser_out_t       predicted [$];
    parser_out_t       seen_out;
    parser_out_t       due_out;

    int                bytes_queued   = 0;
    int                bytes_accepted = 0;
    int                cycle_count    = 0;
    int                fail_count     = 0;
    int                settings_run   = 1;
    int                ev_tally [8];
    int                idle_pct  = 0;
    int                stall_pct = 0;
    int                gap_left  = 0;
    int                stall_left = 0;
    logic              byte_taken = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] modbus_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ 16'hA001;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic void restart_hunt();
        pos_q     = 0;
        framing   = 1'b0;
        len_q     = 8'h00;
        crc_q     = 16'hFFFF;
        crc_hi_ok = 1'b0;
    endfunction

    function automatic void reset_model();
        sync_a = SYNC_FIRST_RST;
        sync_b = SYNC_SECOND_RST;
        att_id = ATT_ID_RST;
        restart_hunt();
        obj_q = '0;
        for (int i = 0; i < 4; i++)
        begin
            stage_w[i] = '0;
            pub_w[i]   = '0;
        end
        att_valid = 1'b0;
        cnt_good  = '0;
        cnt_crc   = '0;
        cnt_other = '0;
    endfunction

    function automatic parser_out_t parse_byte(input logic [7:0] b);
        parser_out_t r;
        logic [EV_W-1:0] ev;
        int p;
        int idx;
        logic good;
        ev = EV_NONE;
        if (!framing)
        begin
            if (pos_q == 0 && b == sync_a)
                pos_q = 1;
            else if (pos_q == 1 && b == sync_b)
                pos_q = 2;
            else if (pos_q == 2)
            begin
                // the rejected length byte is not looked at as a sync byte
                if (b > MAX_LEN)
                begin
                    restart_hunt();
                    ev = EV_LEN_REJECT;
                end
                else
                begin
                    len_q   = b;
                    crc_q   = modbus_step(16'hFFFF, b);
                    framing = 1'b1;
                    pos_q   = 3;
                end
            end
            else
            begin
                restart_hunt();
                if (b == sync_a)
                    pos_q = 1;
            end
        end
        else
        begin
            p = pos_q;
            if (p == OBJ_POS)
                obj_q = b[ID_W-1:0];
            if (p >= BODY_FIRST && p <= BODY_LAST)
            begin
                idx = p - BODY_FIRST;
                stage_w[idx / 4][(idx % 4) * 8 +: 8] = b;
            end
            if (p <= len_q + 2)
                crc_q = modbus_step(crc_q, b);
            else if (p == len_q + 3)
                crc_hi_ok = (b == crc_q[15:8]);
            pos_q = (p + 1) % 512;
            if (p >= len_q + 4)
            begin
                good = crc_hi_ok && (b == crc_q[7:0]);
                if (!good)
                begin
                    cnt_crc++;
                    ev = EV_CRC_ERR;
                end
                else if (obj_q == att_id)
                begin
                    if (len_q == BODY_LEN)
                    begin
                        pub_w = stage_w;
                        if ((stage_w[1] & 32'h7FFF_FFFF) <= LIM_ROLL &&
                            (stage_w[2] & 32'h7FFF_FFFF) <= LIM_PITCH &&
                            (stage_w[3] & 32'h7FFF_FFFF) <= LIM_YAW)
                        begin
                            cnt_good++;
                            att_valid = 1'b1;
                            ev = EV_ATT_OK;
                        end
                        else
                            ev = EV_ATT_REJECT;
                    end
                    else
                        ev = EV_ATT_REJECT;
                end
                else
                begin
                    cnt_other++;
                    ev = EV_OTHER;
                end
                restart_hunt();
            end
            else if (pos_q >= MAX_FRAME)
                restart_hunt();
        end
        r.ev      = ev;
        r.valid   = att_valid;
        r.ts      = pub_w[0];
        r.roll    = pub_w[1];
        r.pitch   = pub_w[2];
        r.yaw     = pub_w[3];
        r.n_good  = cnt_good;
        r.n_crc   = cnt_crc;
        r.n_other = cnt_other;
        return r;
    endfunction

    // ---------------- stimulus building ----------------

    task automatic queue_byte(input logic [7:0] b);
        serial_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_frame(input int len, input logic [7:0] id_byte,
                               input logic [127:0] body, input frame_fault_t fault);
        logic [7:0] fb [$];
        logic [15:0] crc;
        int j;
        int cut;
        fb.push_back(sync_a);
        fb.push_back(sync_b);
        fb.push_back(8'(len));
        for (j = 0; j < len; j++)
        begin
            if (j == 0)
                fb.push_back(id_byte);
            else if (j >= 4 && j < 20)
                fb.push_back(body[(j - 4) * 8 +: 8]);
            else
                fb.push_back(8'($urandom_range(255)));
        end
        crc = 16'hFFFF;
        for (j = 2; j < fb.size(); j++)
            crc = modbus_step(crc, fb[j]);
        fb.push_back(crc[15:8] ^ ((fault == FRAME_BAD_CRC_HI) ? 8'($urandom_range(1, 255)) : 8'h00));
        fb.push_back(crc[7:0] ^ ((fault == FRAME_BAD_CRC_LO) ? 8'($urandom_range(1, 255)) : 8'h00));
        if (fault == FRAME_CUT)
        begin
            cut = $urandom_range(1, 4);
            repeat (cut)
                void'(fb.pop_back());
        end
        for (j = 0; j < fb.size(); j++)
            queue_byte(fb[j]);
    endtask

    function automatic logic [31:0] angle_in(input logic [31:0] lim);
        logic [31:0] mag;
        case ($urandom_range(7))
            0: mag = lim;
            1: mag = 32'h0;
            default: mag = $urandom_range(0, lim);
        endcase
        mag[31] = 1'($urandom_range(1));
        return mag;
    endfunction

    function automatic logic [31:0] angle_out(input logic [31:0] lim);
        logic [31:0] mag;
        case ($urandom_range(5))
            0: mag = lim + 32'd1;
            1: mag = 32'h7F80_0000;                               // infinity
            2: mag = 32'h7FC0_0000 | $urandom_range(0, 32'h3F_FFFF); // nan
            3: mag = 32'h7FFF_FFFF;
            default: mag = $urandom_range(lim + 1, 32'h7F7F_FFFF);
        endcase
        mag[31] = 1'($urandom_range(1));
        return mag;
    endfunction

    function automatic logic [127:0] attitude_body(input bit sane);
        logic [31:0] roll;
        logic [31:0] pitch;
        logic [31:0] yaw;
        int bad;
        bad   = sane ? 3 : $urandom_range(2);
        roll  = (bad == 0 || (!sane && $urandom_range(3) == 0)) ? angle_out(LIM_ROLL)
                                                                : angle_in(LIM_ROLL);
        pitch = (bad == 1 || (!sane && $urandom_range(3) == 0)) ? angle_out(LIM_PITCH)
                                                                : angle_in(LIM_PITCH);
        yaw   = (bad == 2 || (!sane && $urandom_range(3) == 0)) ? angle_out(LIM_YAW)
                                                                : angle_in(LIM_YAW);
        return {yaw, pitch, roll, 32'($urandom)};
    endfunction

    function automatic logic [7:0] id_byte_for(input bit attitude);
        logic [7:0] v;
        v[6:0] = attitude ? att_id : 7'($urandom_range(127));
        if (!attitude && v[6:0] == att_id)
            v[6:0] = v[6:0] ^ 7'h01;
        v[7] = 1'($urandom_range(1));
        return v;
    endfunction

    function automatic int rand_len();
        return ($urandom_range(19) == 0) ? $urandom_range(0, MAX_LEN) : $urandom_range(0, 12);
    endfunction

    task automatic queue_random_traffic(input int n_bytes);
        int start;
        int pick;
        int len;
        start = bytes_queued;
        while (bytes_queued - start < n_bytes)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                queue_frame(BODY_LEN, id_byte_for(1), attitude_body(1), FRAME_CLEAN);
            else if (pick < 40)
                queue_frame(BODY_LEN, id_byte_for(1), attitude_body(0), FRAME_CLEAN);
            else if (pick < 45)
            begin
                len = rand_len();
                if (len == BODY_LEN)
                    len = 0;
                queue_frame(len, id_byte_for(1), attitude_body(1), FRAME_CLEAN);
            end
            else if (pick < 65)
                queue_frame(rand_len(), id_byte_for(0), attitude_body(1), FRAME_CLEAN);
            else if (pick < 72)
                queue_frame($urandom_range(1) ? BODY_LEN : rand_len(), id_byte_for(1),
                            attitude_body(1), FRAME_BAD_CRC_HI);
            else if (pick < 78)
                queue_frame($urandom_range(1) ? BODY_LEN : rand_len(), id_byte_for(1),
                            attitude_body(1), FRAME_BAD_CRC_LO);
            else if (pick < 82)
            begin
                queue_byte(sync_a);
                queue_byte(sync_b);
                queue_byte(8'($urandom_range(MAX_LEN + 1, 255)));
            end
            else if (pick < 87)
                queue_frame($urandom_range(1) ? BODY_LEN : rand_len(), id_byte_for(1),
                            attitude_body(1), FRAME_CUT);
            else if (pick < 93)
            begin
                repeat ($urandom_range(1, 8))
                    queue_byte(($urandom_range(3) == 0) ? sync_a : 8'($urandom_range(255)));
            end
            else
            begin
                // stray first sync byte, sometimes followed by junk
                queue_byte(sync_a);
                if ($urandom_range(1))
                    queue_byte(8'($urandom_range(255)));
                queue_frame(BODY_LEN, id_byte_for(1), attitude_body(1), FRAME_CLEAN);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_SYNC_FIRST:  sync_a = value;
            CFG_SYNC_SECOND: sync_b = value;
            CFG_ATT_ID:      att_id = value[ID_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (bytes_accepted != bytes_queued || predicted.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] id,
                             input int in_idle, input int out_stall, input int n_bytes);
        write_reg(CFG_SYNC_FIRST, s1);
        write_reg(CFG_SYNC_SECOND, s2);
        write_reg(CFG_ATT_ID, id);
        write_reg(CFG_UNUSED, 8'($urandom_range(255)));
        idle_pct  = in_idle;
        stall_pct = out_stall;
        settings_run++;
        queue_random_traffic(n_bytes);
        wait_idle();
    endtask

    function automatic int pause_length();
        return ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    endfunction

    // ---------------- driver, sink and monitor ----------------

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || byte_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (serial_bytes.size() > 0)
            begin
                s_tdata  <= serial_bytes.pop_front();
                s_tvalid <= 1'b1;
                gap_left = ($urandom_range(99) < idle_pct) ? pause_length() + 1 : 0;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(99) < stall_pct)
        begin
            stall_left = pause_length();
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        byte_taken = rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            cycle_count++;
            if (m_tvalid && m_tready)
            begin
                seen_out.ev      = m_tuser[2:0];
                seen_out.valid   = m_tuser[3];
                seen_out.ts      = m_tdata[31:0];
                seen_out.roll    = m_tdata[63:32];
                seen_out.pitch   = m_tdata[95:64];
                seen_out.yaw     = m_tdata[127:96];
                seen_out.n_good  = m_tdata[159:128];
                seen_out.n_crc   = m_tdata[191:160];
                seen_out.n_other = m_tdata[223:192];
                if (predicted.size() == 0)
                begin
                    $error("result item arrived with nothing predicted");
                    fail_count++;
                end
                else
                begin
                    due_out = predicted.pop_front();
                    check_field("event_res", due_out.ev, seen_out.ev);
                    check_field("data_valid", due_out.valid, seen_out.valid);
                    check_field("time_stamp", due_out.ts, seen_out.ts);
                    check_field("roll_bits", due_out.roll, seen_out.roll);
                    check_field("pitch_bits", due_out.pitch, seen_out.pitch);
                    check_field("yaw_bits", due_out.yaw, seen_out.yaw);
                    check_field("good_frames", due_out.n_good, seen_out.n_good);
                    check_field("crc_failures", due_out.n_crc, seen_out.n_crc);
                    check_field("other_frames", due_out.n_other, seen_out.n_other);
                end
            end
            if (byte_taken)
            begin
                due_out = parse_byte(s_tdata);
                predicted.push_back(due_out);
                ev_tally[due_out.ev]++;
                bytes_accepted++;
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("tb_imu_attitude_frame_parser: FAIL");
        $finish;
    end

    // ---------------- test sequence ----------------

    initial
    begin
        for (int i = 0; i < 8; i++)
            ev_tally[i] = 0;
        reset_model();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idle_pct  = 20;
        stall_pct = 20;
        // angles exactly at the limits, negative pitch, all-ones timestamp
        queue_frame(BODY_LEN, {1'b0, att_id},
                    {LIM_YAW, LIM_PITCH | 32'h8000_0000, LIM_ROLL, 32'hFFFF_FFFF}, FRAME_CLEAN);
        // just past the roll limit, then nan yaw, then negative infinite pitch
        queue_frame(BODY_LEN, {1'b1, att_id},
                    {32'h0, 32'h0, LIM_ROLL + 32'd1, 32'h0}, FRAME_CLEAN);
        queue_frame(BODY_LEN, {1'b0, att_id},
                    {32'h7FC0_0001, 32'h0, 32'h0, 32'h1234_5678}, FRAME_CLEAN);
        queue_frame(BODY_LEN, {1'b0, att_id},
                    {32'h0, 32'hFF80_0000, 32'h0, 32'h0}, FRAME_CLEAN);
        // attitude id with the wrong length
        queue_frame(BODY_LEN - 1, {1'b0, att_id}, attitude_body(1), FRAME_CLEAN);
        // empty payload: the id is taken from the first crc byte
        queue_frame(0, 8'h00, '0, FRAME_CLEAN);
        // oversized lengths, one of them equal to the first sync byte
        queue_byte(sync_a);
        queue_byte(sync_b);
        queue_byte(8'hFF);
        queue_byte(sync_a);
        queue_byte(sync_b);
        queue_byte(sync_a);
        // stray first sync bytes before a frame
        queue_byte(sync_a);
        queue_byte(8'h00);
        queue_byte(sync_a);
        queue_frame(1, id_byte_for(0), '0, FRAME_CLEAN);
        queue_frame(2, id_byte_for(0), '0, FRAME_BAD_CRC_LO);
        queue_frame(BODY_LEN, {1'b0, att_id}, attitude_body(1), FRAME_BAD_CRC_HI);
        queue_frame(MAX_LEN, id_byte_for(0), attitude_body(1), FRAME_CLEAN);
        wait_idle();

        run_phase(8'h00, 8'hFF, 8'h00, 0, 0, 170);
        run_phase(8'hFF, 8'h00, 8'hFF, 30, 30, 170);
        run_phase(8'h5A, 8'h5A, 8'd35, 50, 10, 170);
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(127)),
                  10, 50, 170);
        run_phase(SYNC_FIRST_RST, SYNC_SECOND_RST, {1'b0, ATT_ID_RST}, 25, 25, 170);

        $display("%0d bytes over %0d sync/id settings, %0d cycles", bytes_accepted,
                 settings_run, cycle_count);
        $display("events: %0d attitude ok, %0d attitude rejected, %0d other, %0d crc, %0d length",
                 ev_tally[EV_ATT_OK], ev_tally[EV_ATT_REJECT], ev_tally[EV_OTHER],
                 ev_tally[EV_CRC_ERR], ev_tally[EV_LEN_REJECT]);
        if (fail_count == 0 && predicted.size() == 0)
            $display("tb_imu_attitude_frame_parser: PASS");
        else
            $display("tb_imu_attitude_frame_parser: FAIL");
        $finish;
    end

endmodule
